// ===== sv/acwsc_pkg.sv =====
// ----------------------------------------------------------------------------
// acwsc_pkg
// Shared types and constants of the dictionary automaton word-split counter.
// ----------------------------------------------------------------------------
package acwsc_pkg;

  localparam int NODE_COUNT_DEF   = 1024;
  localparam int MAX_WORD_LEN_DEF = 256;
  localparam int ALPHABET_DEF     = 26;

  localparam int WAYS_W    = 30;
  localparam int STATUS_W  = 2;
  localparam int ACTION_W  = 3;
  localparam int LETTER_W  = 5;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  localparam logic [WAYS_W-1:0] WAYS_MOD = WAYS_W'(1000000007);

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD_LETTER = 3'd0,
    ACT_END_WORD   = 3'd1,
    ACT_BUILD      = 3'd2,
    ACT_START_TEXT = 3'd3,
    ACT_TEXT_LETTER = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_TOO_LONG  = 2'd2,
    STS_BAD_PHASE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_LOAD  = 2'd0,
    PH_BUILT = 2'd1,
    PH_TEXT  = 2'd2
  } phase_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_B_POP,
    ST_B_U,
    ST_B_SU,
    ST_B_C0,
    ST_B_C1,
    ST_B_C2,
    ST_B_C3,
    ST_T_MOVE,
    ST_T_OUT,
    ST_W_DEP,
    ST_W_ADD,
    ST_T_FIN,
    ST_RESP
  } state_t;

endpackage

// ===== sv/aho_corasick_word_split_counter_core.sv =====
// ----------------------------------------------------------------------------
// aho_corasick_word_split_counter_core
// Dictionary trie, automaton build and word-split counting over a text.
// ----------------------------------------------------------------------------
// After reset the block sweeps its trie edge memory to zero, one entry a
// cycle, over all NODE_COUNT * 2**ceil(log2(ALPHABET)) entries (32768 at the
// defaults), and takes no transaction meanwhile. Each transaction then gives
// one result. Build runs a breadth-first pass over the trie in memory, with
// one child/transition memory read per letter slot and the output link
// read-back of each child. Each step of a text letter's output-link chain is
// a dependent depth/suffix read then an output-link and count-ring read. A
// result waits in an output register, so the next transaction is taken
// while it is not yet collected.
module aho_corasick_word_split_counter_core #(
  parameter int NODE_COUNT   = acwsc_pkg::NODE_COUNT_DEF,
  parameter int MAX_WORD_LEN = acwsc_pkg::MAX_WORD_LEN_DEF,
  parameter int ALPHABET     = acwsc_pkg::ALPHABET_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [2:0] action, [7:3] letter
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [31:0] out_tdata  // [29:0] ways, [31:30] status
);

  localparam int NW  = $clog2(NODE_COUNT);
  localparam int LW  = $clog2(ALPHABET);
  localparam int TW  = NW + LW;
  localparam int DW  = $clog2(MAX_WORD_LEN + 1);
  localparam int RW  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int SW  = ((DW > RW) ? DW : RW) + 1;
  localparam int WW  = acwsc_pkg::WAYS_W;
  localparam logic [TW:0] CLR_LAST = (TW+1)'((1 << TW) - 1);

  acwsc_pkg::state_t state_r, state_nxt;
  acwsc_pkg::phase_t phase_r, phase_nxt;

  logic [TW:0]   clr_r, clr_nxt;
  logic [NW:0]   nodes_r, nodes_nxt;
  logic [NW-1:0] ins_r, ins_nxt;
  logic [NW-1:0] match_r, match_nxt;
  logic [RW-1:0] tpos_r, tpos_nxt;
  logic [RW-1:0] pos_r, pos_nxt;
  logic [LW-1:0] ltr_r, ltr_nxt;
  logic [NW:0]   head_r, head_nxt;
  logic [NW:0]   tail_r, tail_nxt;
  logic [NW-1:0] u_r, u_nxt;
  logic [NW-1:0] su_r, su_nxt;
  logic [LW-1:0] c_r, c_nxt;
  logic [NW-1:0] v_r, v_nxt;
  logic [NW-1:0] m_r, m_nxt;
  logic [WW-1:0] sum_r, sum_nxt;
  logic          dval_r, dval_nxt;
  logic [WW-1:0] ways_r, ways_nxt;
  logic [1:0]    sts_r, sts_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_data_r, out_data_nxt;

  // memory ports
  logic          ch_we, mv_we, sf_we, ol_we, dp_we, q_we, rg_we;
  logic [TW-1:0] ch_wa, ch_ra, mv_wa, mv_ra;
  logic [NW-1:0] ch_wd, ch_rd, mv_wd, mv_rd;
  logic [NW-1:0] sf_wa, sf_ra, sf_wd, sf_rd;
  logic [NW-1:0] ol_wa, ol_ra, ol_wd, ol_rd;
  logic [NW-1:0] dp_wa, dp_ra;
  logic [DW-1:0] dp_wd, dp_rd;
  logic [NW-1:0] q_wa, q_ra, q_wd, q_rd;
  logic [RW-1:0] rg_wa, rg_ra;
  logic [WW-1:0] rg_wd, rg_rd;

  logic [2:0]    in_act;
  logic [4:0]    in_ltr;
  logic          ltr_ok;
  logic [LW-1:0] ltr_idx;
  logic          accept;
  logic [RW:0]   pos_inc;
  logic [RW-1:0] pos_next;
  logic [SW-1:0] slot_diff;
  logic [RW-1:0] slot;
  logic [WW:0]   sum_add;
  logic [WW-1:0] sum_mod;

  assign in_act  = in_tdata[2:0];
  assign in_ltr  = in_tdata[7:3];
  assign ltr_ok  = int'(in_ltr) < ALPHABET;
  assign ltr_idx = LW'(in_ltr);
  assign accept  = in_tvalid && in_tready;

  assign in_tready  = (state_r == acwsc_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ring position after the current one, kept modulo the word length
  assign pos_inc  = (RW+1)'(tpos_r) + (RW+1)'(1);
  assign pos_next = (pos_inc == (RW+1)'(MAX_WORD_LEN)) ? '0 : RW'(pos_inc);

  // ring slot of the count that a word of depth dp_rd ending here starts at
  always_comb begin
    slot_diff = SW'(pos_r) - SW'(dp_rd);
    if (slot_diff[SW-1]) begin
      slot_diff = slot_diff + SW'(MAX_WORD_LEN);
    end
  end
  assign slot = RW'(slot_diff);

  assign sum_add = (WW+1)'(sum_r) + (WW+1)'(rg_rd);
  assign sum_mod = (sum_add >= (WW+1)'(acwsc_pkg::WAYS_MOD)) ?
                   WW'(sum_add - (WW+1)'(acwsc_pkg::WAYS_MOD)) : WW'(sum_add);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      acwsc_pkg::ST_CLEAR: begin
        if (clr_r == CLR_LAST) state_nxt = acwsc_pkg::ST_IDLE;
      end
      acwsc_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = acwsc_pkg::ST_RESP;
          case (in_act)
            acwsc_pkg::ACT_ADD_LETTER: begin
              if (phase_r == acwsc_pkg::PH_LOAD && ltr_ok) state_nxt = acwsc_pkg::ST_LOAD;
            end
            acwsc_pkg::ACT_BUILD: begin
              if (phase_r == acwsc_pkg::PH_LOAD) state_nxt = acwsc_pkg::ST_B_POP;
            end
            acwsc_pkg::ACT_TEXT_LETTER: begin
              if (phase_r == acwsc_pkg::PH_TEXT) begin
                state_nxt = ltr_ok ? acwsc_pkg::ST_T_MOVE : acwsc_pkg::ST_T_FIN;
              end
            end
            default: state_nxt = acwsc_pkg::ST_RESP;
          endcase
        end
      end
      acwsc_pkg::ST_LOAD:   state_nxt = acwsc_pkg::ST_RESP;
      acwsc_pkg::ST_B_POP: begin
        state_nxt = (head_r == tail_r) ? acwsc_pkg::ST_RESP : acwsc_pkg::ST_B_U;
      end
      acwsc_pkg::ST_B_U:    state_nxt = acwsc_pkg::ST_B_SU;
      acwsc_pkg::ST_B_SU:   state_nxt = acwsc_pkg::ST_B_C0;
      acwsc_pkg::ST_B_C0:   state_nxt = acwsc_pkg::ST_B_C1;
      acwsc_pkg::ST_B_C1,
      acwsc_pkg::ST_B_C2,
      acwsc_pkg::ST_B_C3: begin
        if (state_r == acwsc_pkg::ST_B_C1 && ch_rd != '0) begin
          state_nxt = acwsc_pkg::ST_B_C2;
        end else if (state_r == acwsc_pkg::ST_B_C2 && ol_rd == '0) begin
          state_nxt = acwsc_pkg::ST_B_C3;
        end else if (c_r == LW'(ALPHABET - 1)) begin
          state_nxt = acwsc_pkg::ST_B_POP;
        end else begin
          state_nxt = acwsc_pkg::ST_B_C0;
        end
      end
      acwsc_pkg::ST_T_MOVE: state_nxt = acwsc_pkg::ST_T_OUT;
      acwsc_pkg::ST_T_OUT,
      acwsc_pkg::ST_W_ADD: begin
        state_nxt = (ol_rd == '0) ? acwsc_pkg::ST_T_FIN : acwsc_pkg::ST_W_DEP;
      end
      acwsc_pkg::ST_W_DEP:  state_nxt = acwsc_pkg::ST_W_ADD;
      acwsc_pkg::ST_T_FIN:  state_nxt = acwsc_pkg::ST_RESP;
      acwsc_pkg::ST_RESP: begin
        if (!out_valid_r || out_tready) state_nxt = acwsc_pkg::ST_IDLE;
      end
      default: state_nxt = acwsc_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    phase_nxt = phase_r;
    clr_nxt   = clr_r;
    nodes_nxt = nodes_r;
    ins_nxt   = ins_r;
    match_nxt = match_r;
    tpos_nxt  = tpos_r;
    pos_nxt   = pos_r;
    ltr_nxt   = ltr_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    u_nxt     = u_r;
    su_nxt    = su_r;
    c_nxt     = c_r;
    v_nxt     = v_r;
    m_nxt     = m_r;
    sum_nxt   = sum_r;
    dval_nxt  = dval_r;
    ways_nxt  = ways_r;
    sts_nxt   = sts_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    ch_we = 1'b0; ch_wa = '0; ch_wd = '0; ch_ra = {ins_r, ltr_idx};
    mv_we = 1'b0; mv_wa = {u_r, c_r}; mv_wd = '0; mv_ra = {match_r, ltr_idx};
    sf_we = 1'b0; sf_wa = ch_rd; sf_wd = '0; sf_ra = ol_rd;
    ol_we = 1'b0; ol_wa = '0; ol_wd = '0; ol_ra = mv_rd;
    dp_we = 1'b0; dp_wa = '0; dp_wd = '0; dp_ra = ins_r;
    q_we  = 1'b0; q_wa = tail_r[NW-1:0]; q_wd = '0; q_ra = head_r[NW-1:0];
    rg_we = 1'b0; rg_wa = '0; rg_wd = '0; rg_ra = slot;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      acwsc_pkg::ST_CLEAR: begin
        ch_we = 1'b1;
        ch_wa = clr_r[TW-1:0];
        if (clr_r < (TW+1)'(NODE_COUNT)) begin
          ol_we = 1'b1;
          ol_wa = clr_r[NW-1:0];
          dp_we = 1'b1;
          dp_wa = clr_r[NW-1:0];
          sf_we = 1'b1;
          sf_wa = clr_r[NW-1:0];
        end
        clr_nxt = clr_r + (TW+1)'(1);
      end
      acwsc_pkg::ST_IDLE: begin
        if (accept) begin
          ways_nxt = '0;
          sts_nxt  = acwsc_pkg::STS_BAD_PHASE;
          ltr_nxt  = ltr_idx;
          sum_nxt  = '0;
          pos_nxt  = pos_next;
          case (in_act)
            acwsc_pkg::ACT_ADD_LETTER: begin
              if (phase_r == acwsc_pkg::PH_LOAD && ltr_ok) sts_nxt = acwsc_pkg::STS_OK;
            end
            acwsc_pkg::ACT_END_WORD: begin
              if (phase_r == acwsc_pkg::PH_LOAD) begin
                sts_nxt = acwsc_pkg::STS_OK;
                ol_we   = 1'b1;
                ol_wa   = ins_r;
                ol_wd   = ins_r;
                ins_nxt = '0;
              end
            end
            acwsc_pkg::ACT_BUILD: begin
              if (phase_r == acwsc_pkg::PH_LOAD) begin
                sts_nxt  = acwsc_pkg::STS_OK;
                q_we     = 1'b1;
                q_wa     = '0;
                head_nxt = '0;
                tail_nxt = (NW+1)'(1);
              end
            end
            acwsc_pkg::ACT_START_TEXT: begin
              if (phase_r != acwsc_pkg::PH_LOAD) begin
                sts_nxt   = acwsc_pkg::STS_OK;
                phase_nxt = acwsc_pkg::PH_TEXT;
                match_nxt = '0;
                tpos_nxt  = '0;
                rg_we     = 1'b1;
                rg_wa     = '0;
                rg_wd     = WW'(1);
                ways_nxt  = WW'(1);
              end
            end
            acwsc_pkg::ACT_TEXT_LETTER: begin
              if (phase_r == acwsc_pkg::PH_TEXT) begin
                sts_nxt = acwsc_pkg::STS_OK;
                if (!ltr_ok) match_nxt = '0;
              end
            end
            default: sts_nxt = acwsc_pkg::STS_BAD_PHASE;
          endcase
        end
      end
      acwsc_pkg::ST_LOAD: begin
        if (dp_rd >= DW'(MAX_WORD_LEN)) begin
          sts_nxt = acwsc_pkg::STS_TOO_LONG;
        end else if (ch_rd != '0) begin
          ins_nxt = ch_rd;
        end else if (nodes_r >= (NW+1)'(NODE_COUNT)) begin
          sts_nxt = acwsc_pkg::STS_FULL;
        end else begin
          ch_we     = 1'b1;
          ch_wa     = {ins_r, ltr_r};
          ch_wd     = nodes_r[NW-1:0];
          dp_we     = 1'b1;
          dp_wa     = nodes_r[NW-1:0];
          dp_wd     = dp_rd + DW'(1);
          ins_nxt   = nodes_r[NW-1:0];
          nodes_nxt = nodes_r + (NW+1)'(1);
        end
      end
      acwsc_pkg::ST_B_POP: begin
        if (head_r == tail_r) begin
          ins_nxt   = '0;
          phase_nxt = acwsc_pkg::PH_BUILT;
        end else begin
          head_nxt = head_r + (NW+1)'(1);
        end
      end
      acwsc_pkg::ST_B_U: begin
        u_nxt = q_rd;
        sf_ra = q_rd;
      end
      acwsc_pkg::ST_B_SU: begin
        su_nxt = (u_r == '0) ? '0 : sf_rd;
        c_nxt  = '0;
      end
      acwsc_pkg::ST_B_C0: begin
        ch_ra = {u_r, c_r};
        mv_ra = {su_r, c_r};
      end
      acwsc_pkg::ST_B_C1: begin
        m_nxt = (u_r == '0) ? '0 : mv_rd;
        v_nxt = ch_rd;
        mv_we = 1'b1;
        if (ch_rd != '0) begin
          mv_wd = ch_rd;
          sf_we = 1'b1;
          sf_wd = (u_r == '0) ? '0 : mv_rd;
          ol_ra = ch_rd;
          if (tail_r < (NW+1)'(NODE_COUNT)) begin
            q_we     = 1'b1;
            q_wd     = ch_rd;
            tail_nxt = tail_r + (NW+1)'(1);
          end
        end else begin
          mv_wd = (u_r == '0) ? '0 : mv_rd;
          c_nxt = c_r + LW'(1);
        end
      end
      acwsc_pkg::ST_B_C2: begin
        ol_ra = m_r;
        if (ol_rd != '0) c_nxt = c_r + LW'(1);
      end
      acwsc_pkg::ST_B_C3: begin
        ol_we = 1'b1;
        ol_wa = v_r;
        ol_wd = ol_rd;
        c_nxt = c_r + LW'(1);
      end
      acwsc_pkg::ST_T_MOVE: begin
        match_nxt = mv_rd;
        ol_ra     = mv_rd;
      end
      acwsc_pkg::ST_T_OUT: begin
        dp_ra = ol_rd;
        sf_ra = ol_rd;
      end
      acwsc_pkg::ST_W_DEP: begin
        ol_ra    = sf_rd;
        dval_nxt = (dp_rd != '0) && (dp_rd <= DW'(MAX_WORD_LEN));
      end
      acwsc_pkg::ST_W_ADD: begin
        if (dval_r) sum_nxt = sum_mod;
        dp_ra = ol_rd;
        sf_ra = ol_rd;
      end
      acwsc_pkg::ST_T_FIN: begin
        rg_we    = 1'b1;
        rg_wa    = pos_r;
        rg_wd    = sum_r;
        tpos_nxt = pos_r;
        ways_nxt = sum_r;
      end
      acwsc_pkg::ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {sts_r, ways_r};
        end
      end
      default: begin
        clr_nxt = clr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= acwsc_pkg::ST_CLEAR;
      phase_r     <= acwsc_pkg::PH_LOAD;
      clr_r       <= '0;
      nodes_r     <= (NW+1)'(1);
      ins_r       <= '0;
      match_r     <= '0;
      tpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      clr_r       <= clr_nxt;
      nodes_r     <= nodes_nxt;
      ins_r       <= ins_nxt;
      match_r     <= match_nxt;
      tpos_r      <= tpos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    ltr_r      <= ltr_nxt;
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    u_r        <= u_nxt;
    su_r       <= su_nxt;
    c_r        <= c_nxt;
    v_r        <= v_nxt;
    m_r        <= m_nxt;
    sum_r      <= sum_nxt;
    dval_r     <= dval_nxt;
    ways_r     <= ways_nxt;
    sts_r      <= sts_nxt;
    out_data_r <= out_data_nxt;
  end

  acwsc_ram #(.WIDTH(NW), .DEPTH(1 << TW)) u_child (
    .clk(clk), .we(ch_we), .waddr(ch_wa), .wdata(ch_wd), .raddr(ch_ra), .rdata(ch_rd)
  );
  acwsc_ram #(.WIDTH(NW), .DEPTH(1 << TW)) u_move (
    .clk(clk), .we(mv_we), .waddr(mv_wa), .wdata(mv_wd), .raddr(mv_ra), .rdata(mv_rd)
  );
  acwsc_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_suffix (
    .clk(clk), .we(sf_we), .waddr(sf_wa), .wdata(sf_wd), .raddr(sf_ra), .rdata(sf_rd)
  );
  acwsc_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_outlink (
    .clk(clk), .we(ol_we), .waddr(ol_wa), .wdata(ol_wd), .raddr(ol_ra), .rdata(ol_rd)
  );
  acwsc_ram #(.WIDTH(DW), .DEPTH(NODE_COUNT)) u_depth (
    .clk(clk), .we(dp_we), .waddr(dp_wa), .wdata(dp_wd), .raddr(dp_ra), .rdata(dp_rd)
  );
  acwsc_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd)
  );
  acwsc_ram #(.WIDTH(WW), .DEPTH(MAX_WORD_LEN), .AW(RW)) u_ring (
    .clk(clk), .we(rg_we), .waddr(rg_wa), .wdata(rg_wd), .raddr(rg_ra), .rdata(rg_rd)
  );

endmodule

// ===== sv/acwsc_ram.sv =====
// ----------------------------------------------------------------------------
// acwsc_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module acwsc_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/acwsc_chk.sv =====
// ----------------------------------------------------------------------------
// acwsc_chk
// Port-level checks of the word-split counter, bound to the top level.
// ----------------------------------------------------------------------------
module acwsc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // count stays reduced
  a_ways_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[29:0] < 30'd1000000007)
    else $error("ways out of range");

  // a flagged transaction carries no count
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[31:30] != 2'd0 |-> out_tdata[29:0] == 30'd0)
    else $error("error result with nonzero ways");

  // nothing is taken or shown right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("activity after reset");

endmodule

bind aho_corasick_word_split_counter_core acwsc_chk u_acwsc_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Streams a dictionary, a build and random texts through the word-split
// counter. A scoreboard predicts every result from its own copy of the trie
// and automaton, and checks each result transaction against the oldest one
// still owed.
// ----------------------------------------------------------------------------

class split_scoreboard;
  localparam int NODES  = acwsc_pkg::NODE_COUNT_DEF;
  localparam int WLEN   = acwsc_pkg::MAX_WORD_LEN_DEF;
  localparam int ALPHA  = acwsc_pkg::ALPHABET_DEF;
  localparam int unsigned MODULUS = 1000000007;

  typedef struct packed {
    logic [acwsc_pkg::WAYS_W-1:0]   ways;
    logic [acwsc_pkg::STATUS_W-1:0] status;
  } split_result_t;

  int unsigned trie_edge[NODES*ALPHA];
  int unsigned goto_edge[NODES*ALPHA];
  int unsigned fail_link[NODES];
  int unsigned dict_link[NODES];
  int unsigned depth_of[NODES];
  int unsigned recent_counts[WLEN];
  int unsigned nodes_used;
  int unsigned insert_at;
  int unsigned match_at;
  int unsigned text_pos;
  acwsc_pkg::phase_t phase;
  split_result_t pending_results[$];
  int errors;

  function new();
    foreach (trie_edge[i]) begin
      trie_edge[i] = 0;
      goto_edge[i] = 0;
    end
    foreach (fail_link[i]) begin
      fail_link[i] = 0;
      dict_link[i] = 0;
      depth_of[i]  = 0;
    end
    foreach (recent_counts[i]) recent_counts[i] = 0;
    nodes_used = 1;
    insert_at  = 0;
    match_at   = 0;
    text_pos   = 0;
    phase      = acwsc_pkg::PH_LOAD;
    errors     = 0;
  endfunction

  // Breadth-first pass: suffix links, nearest output links, full goto table.
  function void build_links();
    int unsigned walk[NODES];
    int unsigned head;
    int unsigned tail;
    int unsigned u;
    int unsigned v;
    head = 0;
    tail = 1;
    walk[0] = 0;
    while (head < tail) begin
      u = walk[head];
      head++;
      for (int unsigned c = 0; c < ALPHA; c++) begin
        v = trie_edge[u*ALPHA + c];
        if (v != 0) begin
          depth_of[v]  = depth_of[u] + 1;
          fail_link[v] = (u == 0) ? 0 : goto_edge[fail_link[u]*ALPHA + c];
          if (dict_link[v] == 0) dict_link[v] = dict_link[fail_link[v]];
          goto_edge[u*ALPHA + c] = v;
          if (tail < NODES) begin
            walk[tail] = v;
            tail++;
          end
        end else begin
          goto_edge[u*ALPHA + c] = (u == 0) ? 0 : goto_edge[fail_link[u]*ALPHA + c];
        end
      end
    end
  endfunction

  function void note_input(logic [acwsc_pkg::ACTION_W-1:0] act,
                           logic [acwsc_pkg::LETTER_W-1:0] ltr);
    split_result_t r;
    int unsigned idx;
    int unsigned pos;
    int unsigned sum;
    int unsigned v;
    int unsigned d;
    r.ways   = '0;
    r.status = acwsc_pkg::STS_OK;
    case (act)
      acwsc_pkg::ACT_ADD_LETTER: begin
        if (phase != acwsc_pkg::PH_LOAD || ltr >= ALPHA) begin
          r.status = acwsc_pkg::STS_BAD_PHASE;
        end else if (depth_of[insert_at] >= WLEN) begin
          r.status = acwsc_pkg::STS_TOO_LONG;
        end else begin
          idx = insert_at*ALPHA + ltr;
          if (trie_edge[idx] != 0) begin
            insert_at = trie_edge[idx];
          end else if (nodes_used >= NODES) begin
            r.status = acwsc_pkg::STS_FULL;
          end else begin
            trie_edge[idx] = nodes_used;
            depth_of[nodes_used] = depth_of[insert_at] + 1;
            insert_at = nodes_used;
            nodes_used++;
          end
        end
      end
      acwsc_pkg::ACT_END_WORD: begin
        if (phase != acwsc_pkg::PH_LOAD) begin
          r.status = acwsc_pkg::STS_BAD_PHASE;
        end else begin
          dict_link[insert_at] = insert_at;
          insert_at = 0;
        end
      end
      acwsc_pkg::ACT_BUILD: begin
        if (phase != acwsc_pkg::PH_LOAD) begin
          r.status = acwsc_pkg::STS_BAD_PHASE;
        end else begin
          build_links();
          insert_at = 0;
          phase = acwsc_pkg::PH_BUILT;
        end
      end
      acwsc_pkg::ACT_START_TEXT: begin
        if (phase == acwsc_pkg::PH_LOAD) begin
          r.status = acwsc_pkg::STS_BAD_PHASE;
        end else begin
          phase = acwsc_pkg::PH_TEXT;
          match_at = 0;
          text_pos = 0;
          recent_counts[0] = 1;
          r.ways = 1;
        end
      end
      acwsc_pkg::ACT_TEXT_LETTER: begin
        if (phase != acwsc_pkg::PH_TEXT) begin
          r.status = acwsc_pkg::STS_BAD_PHASE;
        end else begin
          pos = (text_pos + 1) % WLEN;
          sum = 0;
          if (ltr >= ALPHA) begin
            match_at = 0;
          end else begin
            match_at = goto_edge[match_at*ALPHA + ltr];
            v = dict_link[match_at];
            while (v != 0) begin
              d = depth_of[v];
              if (d >= 1 && d <= WLEN) begin
                sum += recent_counts[(pos + WLEN - d) % WLEN];
                if (sum >= MODULUS) sum -= MODULUS;
              end
              v = dict_link[fail_link[v]];
            end
          end
          recent_counts[pos] = sum;
          text_pos = pos;
          r.ways = sum;
        end
      end
      default: r.status = acwsc_pkg::STS_BAD_PHASE;
    endcase
    pending_results.push_back(r);
  endfunction

  task report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  task check_result(logic [acwsc_pkg::WAYS_W-1:0] ways,
                    logic [acwsc_pkg::STATUS_W-1:0] status);
    split_result_t e;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result ways=%0d status=%0d", ways, status));
    end else begin
      e = pending_results.pop_front();
      if (ways !== e.ways)
        report_mismatch($sformatf("ways %0d, predicted %0d", ways, e.ways));
      if (status !== e.status)
        report_mismatch($sformatf("status %0d, predicted %0d", status, e.status));
    end
  endtask
endclass

module tb;
  localparam int AW = acwsc_pkg::ACTION_W;
  localparam int LTW = acwsc_pkg::LETTER_W;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  split_scoreboard sb;
  int sent_count;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_request;

  aho_corasick_word_split_counter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Shift the idle mix as the run goes on.
  always @(sent_count) begin
    if (sent_count < 600) begin
      send_idle_pct = 15;
      recv_idle_pct = 85;
    end else if (sent_count < 1200) begin
      send_idle_pct = 85;
      recv_idle_pct = 15;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  always @(negedge clk) begin
    if (stall_request > 0) begin
      out_tready <= 1'b0;
      stall_request <= stall_request - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[29:0], out_tdata[31:30]);
  end

  task send_item(logic [AW-1:0] act, logic [LTW-1:0] ltr);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ltr, act};
    do @(posedge clk); while (!in_tready);
    sb.note_input(act, ltr);
    sent_count++;
  endtask

  task send_word(string w);
    foreach (w[i]) send_item(acwsc_pkg::ACT_ADD_LETTER, LTW'(w[i] - "a"));
    send_item(acwsc_pkg::ACT_END_WORD, LTW'(0));
  endtask

  function automatic logic [LTW-1:0] text_letter();
    int r;
    r = $urandom_range(99);
    if (r < 80) return LTW'($urandom_range(1));
    if (r < 95) return LTW'($urandom_range(25));
    return LTW'($urandom_range(31, 26));
  endfunction

  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int n;
    int r;
    sb = new();
    sent_count = 0;
    send_idle_pct = 15;
    recv_idle_pct = 85;
    stall_request = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wrong phase and out-of-alphabet while loading, then an empty word.
    send_item(acwsc_pkg::ACT_START_TEXT, LTW'(0));
    send_item(acwsc_pkg::ACT_TEXT_LETTER, LTW'(3));
    send_item(3'd5, 5'd31);
    send_item(3'd6, 5'd16);
    send_item(3'd7, 5'd8);
    send_item(acwsc_pkg::ACT_ADD_LETTER, 5'd26);
    send_item(acwsc_pkg::ACT_ADD_LETTER, 5'd31);
    send_item(acwsc_pkg::ACT_END_WORD, LTW'(0));
    send_word("a");
    send_word("b");
    send_word("ab");
    send_word("ba");
    send_word("aab");
    send_word("zyx");

    // One letter beyond the longest word; the 256-letter prefix is marked.
    for (int i = 0; i < 257; i++) send_item(acwsc_pkg::ACT_ADD_LETTER, LTW'(0));
    send_item(acwsc_pkg::ACT_END_WORD, LTW'(0));

    // Fill the node table, then push past it.
    while (sb.nodes_used < acwsc_pkg::NODE_COUNT_DEF) begin
      n = $urandom_range(8, 2);
      for (int i = 0; i < n; i++)
        send_item(acwsc_pkg::ACT_ADD_LETTER,
                  ($urandom_range(3) == 0) ? LTW'($urandom_range(1))
                                           : LTW'($urandom_range(25)));
      if ($urandom_range(9) != 0) send_item(acwsc_pkg::ACT_END_WORD, LTW'(0));
    end
    for (int i = 0; i < 6; i++)
      send_item(acwsc_pkg::ACT_ADD_LETTER, LTW'($urandom_range(25)));
    send_item(acwsc_pkg::ACT_END_WORD, LTW'(0));
    send_item(acwsc_pkg::ACT_ADD_LETTER, LTW'(1));
    send_item(acwsc_pkg::ACT_ADD_LETTER, LTW'(0));
    send_item(acwsc_pkg::ACT_BUILD, LTW'(0));

    // Load actions after build, text before start, two starts.
    send_item(acwsc_pkg::ACT_ADD_LETTER, LTW'(2));
    send_item(acwsc_pkg::ACT_END_WORD, LTW'(0));
    send_item(acwsc_pkg::ACT_BUILD, LTW'(0));
    send_item(acwsc_pkg::ACT_TEXT_LETTER, LTW'(0));
    send_item(acwsc_pkg::ACT_START_TEXT, LTW'(0));
    send_item(acwsc_pkg::ACT_START_TEXT, LTW'(0));

    // Long receiver hold-off so the block backs up onto its input.
    stall_request = 300;
    for (int i = 0; i < 260; i++) send_item(acwsc_pkg::ACT_TEXT_LETTER, LTW'(0));

    while (sent_count < 1850) begin
      r = $urandom_range(99);
      if (r < 95)      send_item(acwsc_pkg::ACT_TEXT_LETTER, text_letter());
      else if (r < 97) send_item(acwsc_pkg::ACT_START_TEXT, LTW'($urandom));
      else             send_item(AW'(acwsc_pkg::ACT_ADD_LETTER + AW'($urandom_range(2)) +
                                 (($urandom_range(1) == 1) ? AW'(5) : AW'(0))),
                                 LTW'($urandom));
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
